@@ rtl/mwh_pkg.sv @@
// Shared types and constants of the word hash block.
package mwh_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 3;
  // Input beat payload rounded up to whole bytes.
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 32;

  localparam logic [WordW-1:0] HashMul   = 32'h5bd1_e995;
  localparam int unsigned      WordShift = 16;
  localparam int unsigned      TailShift = 24;

  typedef struct packed {
    logic [WordW-1:0]  data_word;
    logic [CountW-1:0] byte_count;
    logic              last;
  } item_t;

endpackage

@@ rtl/murmur_style_word_hash.sv @@
// Top level of the word hash block: input register, mixing step and result register.
//
// A message arrives on the s_ channel as little-endian 32-bit words, one per
// beat, with the count of valid bytes beside each word and s_tlast on its
// final beat. Only the final beat may carry fewer than four bytes. The
// finished 32-bit hash leaves on the m_ channel as one beat per message.
//
// A beat is taken into the input register. A non-final beat is mixed into
// the running hash at the next clock edge. A final beat is mixed once the
// result register is free or being read; at that edge its hash is loaded
// into the result register and m_tvalid rises. The block accepts one beat
// every cycle while s_tready is high; the rate is set by the add, multiply
// and fold loop that feeds the running hash back into itself.
//
// While the receiver holds m_tready low the result waits in its register and
// the block goes on hashing non-final beats; a second final beat waits in the
// input register, and only then does s_tready fall.
//
// Reset clears the running hash to zero and empties both registers.
module murmur_style_word_hash (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [mwh_pkg::InDataW-1:0]    s_tdata,  // data_word[31:0], byte_count[34:32], zeros
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [mwh_pkg::OutDataW-1:0]   m_tdata   // hash_value[31:0]
);

  mwh_pkg::item_t            item_q;
  logic                      in_valid;
  logic [mwh_pkg::WordW-1:0] running_hash;
  logic [mwh_pkg::WordW-1:0] hash_next;
  logic [mwh_pkg::WordW-1:0] hash_value;
  logic                      out_free;
  logic                      advance;
  logic                      in_take;

  mwh_mix u_mix (
    .hash_in  (running_hash),
    .item     (item_q),
    .hash_out (hash_next)
  );

  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && (!item_q.last || out_free);
  assign s_tready = !in_valid || advance;
  assign in_take  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_q.data_word  <= s_tdata[mwh_pkg::WordW-1:0];
      item_q.byte_count <= s_tdata[mwh_pkg::WordW+mwh_pkg::CountW-1:mwh_pkg::WordW];
      item_q.last       <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
    end else if (advance) begin
      running_hash <= item_q.last ? '0 : hash_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && item_q.last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_q.last) begin
      hash_value <= hash_next;
    end
  end

  assign m_tdata = hash_value;

  a_reset_empty : assert property (@(posedge clk) rst |=> !m_tvalid && !in_valid)
    else $error("output or input register not empty after reset");

  a_clear_after_last : assert property (@(posedge clk) disable iff (rst)
    advance && item_q.last |=> running_hash == '0)
    else $error("running hash not cleared after a final beat");

  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |-> !s_tready)
    else $error("input register could be overwritten while it holds a beat");

  a_result_held : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(hash_value))
    else $error("stalled result changed or was dropped");

endmodule

@@ rtl/mwh_mix.sv @@
// Mix: add valid bytes, multiply by constant, fold high bits down; empty beat: hash kept.
module mwh_mix (
  input  logic [mwh_pkg::WordW-1:0] hash_in,
  input  mwh_pkg::item_t            item,
  output logic [mwh_pkg::WordW-1:0] hash_out
);

  logic [mwh_pkg::WordW-1:0] add_word;
  logic [mwh_pkg::WordW-1:0] sum;
  logic [mwh_pkg::WordW-1:0] prod;
  logic                      is_tail;
  logic                      is_empty;

  always_comb begin
    add_word = item.data_word;
    is_tail  = 1'b0;
    is_empty = 1'b0;
    case (item.byte_count)
      3'd0: begin
        is_empty = 1'b1;
      end
      3'd1: begin
        add_word = {24'h0, item.data_word[7:0]};
        is_tail  = 1'b1;
      end
      3'd2: begin
        add_word = {16'h0, item.data_word[15:0]};
        is_tail  = 1'b1;
      end
      3'd3: begin
        add_word = {8'h0, item.data_word[23:0]};
        is_tail  = 1'b1;
      end
      default: begin
        // Counts of four and above all take the full word.
        add_word = item.data_word;
      end
    endcase
  end

  assign sum  = hash_in + add_word;
  assign prod = sum * mwh_pkg::HashMul;

  always_comb begin
    if (is_empty) begin
      hash_out = hash_in;
    end else if (is_tail) begin
      hash_out = prod ^ (prod >> mwh_pkg::TailShift);
    end else begin
      hash_out = prod ^ (prod >> mwh_pkg::WordShift);
    end
  end

endmodule
